FILE: rtl/msac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msac_pkg: shared types and constants of the masked signature classifier
// Command codes, stream packing, the queued operation and the result word.
// ----------------------------------------------------------------------------
package msac_pkg;

    localparam int DATA_IN_W  = 224;
    localparam int DATA_OUT_W = 24;
    localparam int CFG_W      = 6;

    localparam logic [1:0] CMD_SIG_WR   = 2'd0;
    localparam logic [1:0] CMD_APP_WR   = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [1:0] {
        KIND_SIG_WR,
        KIND_APP_WR,
        KIND_PASS,
        KIND_SCAN
    } op_kind_t;

    // sig carries the payload bytes for classify operations
    typedef struct packed {
        op_kind_t    kind;
        logic [4:0]  app_slot;
        logic [2:0]  feature_slot;
        logic        slot_valid;
        logic [63:0] sig;
        logic [63:0] mask;
        logic [15:0] app_id;
        logic        detect_enable;
        logic        pass_next;
    } op_t;

    typedef struct packed {
        logic        analysis_done;
        logic [15:0] app_id_out;
        logic        hit;
        logic        next_stage;
    } res_t;

    typedef struct packed {
        logic scanning;
        logic holding;
    } bk_status_t;

endpackage
`default_nettype wire

FILE: rtl/msac_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msac_front: command decode and operation queue
// Accepts stream transactions, drops ignored commands, classifies the rest
// into operations and queues them for the back end.
// ----------------------------------------------------------------------------
module msac_front
    import msac_pkg::*;
#(
    parameter int MAX_APPS      = 32,
    parameter int SLOTS_PER_APP = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [DATA_IN_W-1:0] s_axis_tdata,
    input  wire logic [1:0]           s_axis_tuser,
    input  wire logic                 q_pop,
    output logic                      q_valid,
    output op_t                       q_op
);

    op_t                dec_op;
    logic               dec_keep;
    logic               push;
    op_t                q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    logic [4:0]  f_app_slot;
    logic [2:0]  f_feature_slot;
    logic        f_needs;
    logic        f_skip_pkt;

    assign f_app_slot     = s_axis_tdata[4:0];
    assign f_feature_slot = s_axis_tdata[7:5];
    assign f_needs        = s_axis_tdata[218];
    assign f_skip_pkt     = s_axis_tdata[219];

    always_comb
    begin
        dec_op.kind          = KIND_PASS;
        dec_op.app_slot      = f_app_slot;
        dec_op.feature_slot  = f_feature_slot;
        dec_op.slot_valid    = s_axis_tdata[8];
        dec_op.sig           = s_axis_tdata[72:9];
        dec_op.mask          = s_axis_tdata[136:73];
        dec_op.app_id        = s_axis_tdata[152:137];
        dec_op.detect_enable = s_axis_tdata[153];
        dec_op.pass_next     = ~f_skip_pkt;
        dec_keep             = 1'b0;
        unique case (s_axis_tuser)
            CMD_SIG_WR:
            begin
                dec_op.kind = KIND_SIG_WR;
                dec_keep    = (f_app_slot < MAX_APPS) && (f_feature_slot < SLOTS_PER_APP);
            end
            CMD_APP_WR:
            begin
                dec_op.kind = KIND_APP_WR;
                dec_keep    = f_app_slot < MAX_APPS;
            end
            CMD_CLASSIFY:
            begin
                dec_op.kind = (f_skip_pkt || !f_needs) ? KIND_PASS : KIND_SCAN;
                dec_op.sig  = s_axis_tdata[217:154];
                dec_keep    = 1'b1;
            end
            default:
            begin
                dec_keep = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign push          = s_axis_tvalid && s_axis_tready && dec_keep;
    assign q_valid       = cnt_reg != '0;
    assign q_op          = q_mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push  ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = q_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wptr_reg] <= dec_op;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/msac_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msac_back: application table and scan engine
// Executes table writes, scans one application entry per cycle with all
// its signature slots compared in parallel, and drives the output register.
// ----------------------------------------------------------------------------
module msac_back
    import msac_pkg::*;
#(
    parameter int SIG_BYTES     = 8,
    parameter int MAX_APPS      = 32,
    parameter int SLOTS_PER_APP = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_W-1:0]      cfg_wr_data,
    input  wire logic                  q_valid,
    input  wire op_t                   q_op,
    output logic                       q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [DATA_OUT_W-1:0]      m_axis_tdata,
    output bk_status_t                 status
);

    localparam int AW = (MAX_APPS > 1) ? $clog2(MAX_APPS) : 1;
    localparam int SW = (SLOTS_PER_APP > 1) ? $clog2(SLOTS_PER_APP) : 1;
    localparam int CW = $clog2(MAX_APPS + 1);
    localparam logic [63:0] WIN = {64{1'b1}} >> (64 - 8 * SIG_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } bk_state_t;

    bk_state_t               state_reg, state_next;
    logic [CFG_W-1:0]        app_count_reg;
    logic [CW-1:0]           n_sat;
    logic [CW-1:0]           n_reg;
    logic [CW-1:0]           cmp_idx_reg;
    logic [63:0]             payload_reg;
    res_t                    res_reg;
    res_t                    out_res;
    res_t                    out_data_reg;
    logic                    out_valid_reg;
    logic                    out_free;
    logic                    load_out;
    logic                    start;
    logic                    scan_end;
    logic                    cmp_last;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    wr_sig;
    logic                    wr_app;

    logic [SLOTS_PER_APP-1:0] present_reg [MAX_APPS];
    logic [MAX_APPS-1:0]      enable_reg;
    logic [15:0]              id_mem [MAX_APPS];
    logic [15:0]              rd_id_reg;
    logic [SLOTS_PER_APP-1:0] rd_present_reg;
    logic                     rd_enable_reg;
    logic [63:0]              rd_sig_reg  [SLOTS_PER_APP];
    logic [63:0]              rd_mask_reg [SLOTS_PER_APP];
    logic [SLOTS_PER_APP-1:0] slot_hit;
    logic                     entry_hit;

    always_comb
    begin
        if (int'(app_count_reg) > MAX_APPS)
        begin
            n_sat = CW'(MAX_APPS);
        end
        else
        begin
            n_sat = CW'(app_count_reg);
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;
    assign cmp_last = cmp_idx_reg == (n_reg - CW'(1));
    assign wr_addr  = AW'(q_op.app_slot);
    assign wr_sig   = q_pop && (q_op.kind == KIND_SIG_WR);
    assign wr_app   = q_pop && (q_op.kind == KIND_APP_WR);

    always_comb
    begin
        for (int s = 0; s < SLOTS_PER_APP; s++)
        begin
            slot_hit[s] = rd_present_reg[s]
                && (((payload_reg ^ rd_sig_reg[s]) & rd_mask_reg[s] & WIN) == '0);
        end
    end

    assign entry_hit = rd_enable_reg && (|slot_hit);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        out_res    = '0;
        start      = 1'b0;
        scan_end   = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_op.kind) inside
                        KIND_SIG_WR, KIND_APP_WR:
                        begin
                            q_pop = 1'b1;
                        end
                        KIND_PASS:
                        begin
                            if (out_free)
                            begin
                                q_pop              = 1'b1;
                                load_out           = 1'b1;
                                out_res.next_stage = q_op.pass_next;
                            end
                        end
                        KIND_SCAN:
                        begin
                            if (n_sat == '0)
                            begin
                                if (out_free)
                                begin
                                    q_pop              = 1'b1;
                                    load_out           = 1'b1;
                                    out_res.next_stage = 1'b1;
                                end
                            end
                            else
                            begin
                                q_pop      = 1'b1;
                                start      = 1'b1;
                                rd_en      = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (entry_hit || cmp_last)
                begin
                    scan_end   = 1'b1;
                    state_next = ST_HOLD;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(cmp_idx_reg + CW'(1));
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    out_res    = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            app_count_reg <= '0;
            cmp_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            enable_reg    <= '0;
            for (int a = 0; a < MAX_APPS; a++)
            begin
                present_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                app_count_reg <= cfg_wr_data;
            end
            if (start)
            begin
                cmp_idx_reg <= '0;
            end
            else if (rd_en)
            begin
                cmp_idx_reg <= cmp_idx_reg + CW'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_app)
            begin
                enable_reg[wr_addr] <= q_op.detect_enable;
            end
            if (wr_sig)
            begin
                present_reg[wr_addr][SW'(q_op.feature_slot)] <= q_op.slot_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            payload_reg <= q_op.sig;
            n_reg       <= n_sat;
        end
        if (scan_end)
        begin
            res_reg.next_stage <= 1'b1;
            res_reg.hit        <= entry_hit;
            res_reg.app_id_out <= entry_hit ? rd_id_reg : 16'd0;
            res_reg.analysis_done <= entry_hit;
        end
        if (load_out)
        begin
            out_data_reg <= out_res;
        end
        if (wr_app)
        begin
            id_mem[wr_addr] <= q_op.app_id;
        end
        if (rd_en)
        begin
            rd_id_reg      <= id_mem[rd_addr];
            rd_present_reg <= present_reg[rd_addr];
            rd_enable_reg  <= enable_reg[rd_addr];
        end
    end

    for (genvar s = 0; s < SLOTS_PER_APP; s++)
    begin : g_slot
        logic [63:0] sig_mem  [MAX_APPS];
        logic [63:0] mask_mem [MAX_APPS];

        always_ff @(posedge clk)
        begin
            if (wr_sig && (q_op.feature_slot == s))
            begin
                sig_mem[wr_addr]  <= q_op.sig;
                mask_mem[wr_addr] <= q_op.mask;
            end
            if (rd_en)
            begin
                rd_sig_reg[s]  <= sig_mem[rd_addr];
                rd_mask_reg[s] <= mask_mem[rd_addr];
            end
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {(DATA_OUT_W - $bits(res_t))'(0), out_data_reg};
    assign status.scanning = state_reg == ST_SCAN;
    assign status.holding  = state_reg == ST_HOLD;

endmodule
`default_nettype wire

FILE: rtl/masked_signature_app_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masked_signature_app_classifier: packet application classifier
// Masked byte-signature matching over a prioritized application table.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser holds the command, tdata the fields.
//   Signature and application writes update the table and give no result.
//   A classify transaction gives one result transaction on m_axis.
//   cfg_wr_en/cfg_wr_data load app_count; write it only while idle.
// Flow:
//   A write, a skipped packet, one that needs no analysis, or a classify
//   with n = 0 is handled in IDLE without a scan. A classify with analysis
//   scans one entry per cycle over n = min(app_count, MAX_APPS) entries,
//   stopping at the first match, and its result goes through HOLD into
//   the output register.
// Reset:
//   Slot present bits, entry enables, app_count and the queue are cleared.
// Stall:
//   The output register holds a result until taken. Writes at the head of
//   the two-entry queue still execute while the back end is idle; the next
//   result waits in the back end, and s_axis_tready drops while the queue is full.
// ----------------------------------------------------------------------------
module masked_signature_app_classifier
    import msac_pkg::*;
#(
    parameter int SIG_BYTES     = 8,
    parameter int MAX_APPS      = 32,
    parameter int SLOTS_PER_APP = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_W-1:0]      cfg_wr_data,   // app_count
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // app_slot, feature_slot, slot_valid, sig_bytes, mask_bytes, app_id_in,
    // detect_enable, payload_bytes, needs_analysis, skip_pkt
    input  wire logic [DATA_IN_W-1:0]  s_axis_tdata,
    input  wire logic [1:0]            s_axis_tuser,  // cmd
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // next_stage, hit, app_id_out, analysis_done
    output logic [DATA_OUT_W-1:0]      m_axis_tdata
);

    logic       q_valid;
    op_t        q_op;
    logic       q_pop;
    bk_status_t bk_status;

    msac_front #(
        .MAX_APPS      (MAX_APPS),
        .SLOTS_PER_APP (SLOTS_PER_APP)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_pop         (q_pop),
        .q_valid       (q_valid),
        .q_op          (q_op)
    );

    msac_back #(
        .SIG_BYTES     (SIG_BYTES),
        .MAX_APPS      (MAX_APPS),
        .SLOTS_PER_APP (SLOTS_PER_APP)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .status        (bk_status)
    );

`ifndef SYNTH
    a_no_pop_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_status.scanning || bk_status.holding) |-> !q_pop)
        else $error("queue popped while a scan is in progress");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(q_pop || bk_status.holding))
        else $error("result appeared without a source operation");

    a_hit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[0] && m_axis_tdata[18]))
        else $error("hit without next_stage or analysis_done");
`endif

endmodule
`default_nettype wire
